### design/assert_macros.svh
// Assertion helper macros for the decoder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### design/mfd_pkg.sv
// Shared types, constants and functions of the frame decoder.
// No dependencies.
`default_nettype none
package mfd_pkg;
  localparam logic [7:0] StartV1 = 8'hFE;
  localparam logic [7:0] StartV2 = 8'hFD;
  localparam logic [7:0] SigLen = 8'd13;
  localparam logic [2:0] KindNone = 3'd7;
  localparam int unsigned QueueDepth = 4;

  // Completed frame handed from the parser to the result stage.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sys;
    logic [7:0] comp;
    logic [7:0][31:0] words;
  } frame_t;

  // CRC-16/MCRF4XX byte update.
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] c);
    logic [7:0] t;
    t = b ^ c[7:0];
    t = t ^ {t[3:0], 4'b0};
    return {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'b0, t[7:4]};
  endfunction

  function automatic logic [2:0] kind_of(input logic [23:0] id);
    case (id)
      24'd0: return 3'd0;
      24'd24: return 3'd1;
      24'd30: return 3'd2;
      24'd33: return 3'd3;
      24'd42: return 3'd4;
      24'd136: return 3'd5;
      24'd242: return 3'd6;
      default: return KindNone;
    endcase
  endfunction

  function automatic logic [7:0] kind_extra(input logic [2:0] k);
    case (k)
      3'd0: return 8'd50;
      3'd1: return 8'd24;
      3'd2: return 8'd39;
      3'd3: return 8'd104;
      3'd4: return 8'd28;
      3'd5: return 8'd1;
      3'd6: return 8'd104;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] kind_min(input logic [2:0] k);
    case (k)
      3'd0: return 8'd9;
      3'd1: return 8'd30;
      3'd2: return 8'd28;
      3'd3: return 8'd28;
      3'd4: return 8'd2;
      3'd5: return 8'd22;
      3'd6: return 8'd52;
      default: return 8'd255;
    endcase
  endfunction

  // Capture map: word index (bit 3 = valid) and byte lane for a payload offset.
  function automatic logic [5:0] seg_map(input logic [2:0] k, input logic [7:0] p);
    logic [3:0] w;
    logic [1:0] l;
    w = 4'd0;
    l = 2'd0;
    case (k)
      3'd0: if (p >= 8'd4 && p <= 8'd7) w = {1'b1, 3'(p - 8'd4)};
      3'd1: begin
        if (p >= 8'd8 && p <= 8'd19) begin
          w = {1'b1, 3'((p - 8'd8) >> 2)};
          l = p[1:0];
        end else if (p == 8'd28) w = {1'b1, 3'd3};
        else if (p == 8'd29) w = {1'b1, 3'd4};
      end
      3'd2: if (p >= 8'd4 && p <= 8'd15) begin
        w = {1'b1, 3'((p - 8'd4) >> 2)};
        l = p[1:0];
      end
      3'd3: begin
        if (p >= 8'd4 && p <= 8'd19) begin
          w = {1'b1, 3'((p - 8'd4) >> 2)};
          l = p[1:0];
        end else if (p >= 8'd20 && p <= 8'd27) begin
          w = {1'b1, 3'(3'd4 + 3'((p - 8'd20) >> 1))};
          l = {1'b0, p[0]};
        end
      end
      3'd4: if (p <= 8'd1) begin
        w = {1'b1, 3'd0};
        l = {1'b0, p[0]};
      end
      3'd5: begin
        if (p <= 8'd7) begin
          w = {1'b1, 3'(p >> 2)};
          l = p[1:0];
        end else if (p >= 8'd10 && p <= 8'd17) begin
          w = {1'b1, 3'(3'd2 + 3'((p - 8'd10) >> 2))};
          l = 2'(p - 8'd10);
        end else if (p >= 8'd18 && p <= 8'd21) begin
          w = {1'b1, 3'(3'd4 + 3'((p - 8'd18) >> 1))};
          l = {1'b0, p[0]};
        end
      end
      3'd6: if (p <= 8'd11) begin
        w = {1'b1, 3'(p >> 2)};
        l = p[1:0];
      end
      default: ;
    endcase
    return {w, l};
  endfunction
endpackage
`default_nettype wire

### design/mfd_parser.sv
// Front end: byte-level frame parser with CRC and field capture.
// Depends on mfd_pkg; emits one frame_t per good frame.
`default_nettype none
module mfd_parser import mfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_take,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_datagram,
  output frame_t          frame,
  output logic            frame_valid
);
  typedef enum logic [2:0] {HUNT, HEADER, PAYLOAD, CRC, SIG} phase_t;

  phase_t phase;
  logic v2, signed_f, crc_ok;
  logic [7:0] pos, plen, sys, comp, crc_lo;
  logic [23:0] msg_id;
  logic [15:0] crc;
  logic [2:0] kind;
  logic [7:0][31:0] words;
  logic [5:0] seg;
  logic [15:0] crc_next;
  logic [7:0] pos_next;

  assign kind = kind_of(msg_id);
  assign seg = seg_map(kind, pos);
  assign crc_next = crc_step(data_byte, crc);
  assign pos_next = pos + 8'd1;

  // Finished frame with field fixups applied.
  always_comb begin
    frame.kind = kind;
    frame.sys = sys;
    frame.comp = comp;
    frame.words = words;
    case (kind)
      3'd0: frame.words[4] = {31'b0, words[2][7]};
      3'd1: if (words[4] == 32'd255) frame.words[4] = '1;
      3'd3: begin
        frame.words[4] = {{16{words[4][15]}}, words[4][15:0]};
        frame.words[5] = {{16{words[5][15]}}, words[5][15:0]};
        frame.words[6] = {{16{words[6][15]}}, words[6][15:0]};
        if (words[7] == 32'd65535) frame.words[7] = '0;
      end
      default: ;
    endcase
  end

  // Parse state machine.
  always_ff @(posedge clk) begin
    frame_valid <= 1'b0;
    if (rst) begin
      phase <= HUNT;
      v2 <= 1'b0; signed_f <= 1'b0; crc_ok <= 1'b0;
      pos <= '0; plen <= '0; sys <= '0; comp <= '0; crc_lo <= '0;
      msg_id <= '0; crc <= 16'hFFFF; words <= '0;
    end else if (in_take) begin
      case (phase)
        HUNT: if (data_byte == StartV1 || data_byte == StartV2) begin
          v2 <= (data_byte == StartV2);
          signed_f <= 1'b0; pos <= '0; plen <= '0; sys <= '0; comp <= '0;
          msg_id <= '0; crc <= 16'hFFFF; words <= '0;
          phase <= HEADER;
        end
        HEADER: begin
          crc <= crc_next;
          if (pos == 8'd0) plen <= data_byte;
          if (v2) begin
            if (pos == 8'd1) signed_f <= data_byte[0];
            else if (pos == 8'd4) sys <= data_byte;
            else if (pos == 8'd5) comp <= data_byte;
            else if (pos == 8'd6) msg_id[7:0] <= data_byte;
            else if (pos == 8'd7) msg_id[15:8] <= data_byte;
            else if (pos == 8'd8) msg_id[23:16] <= data_byte;
          end else begin
            if (pos == 8'd2) sys <= data_byte;
            else if (pos == 8'd3) comp <= data_byte;
            else if (pos == 8'd4) msg_id <= {16'b0, data_byte};
          end
          pos <= pos_next;
          if (pos_next >= (v2 ? 8'd9 : 8'd5)) begin
            pos <= '0;
            phase <= ((pos == 8'd0 ? data_byte : plen) != 8'd0) ? PAYLOAD : CRC;
          end
        end
        PAYLOAD: begin
          crc <= crc_next;
          if (seg[5]) words[seg[4:2]][8*seg[1:0] +: 8] <= data_byte;
          pos <= pos_next;
          if (pos_next >= plen) begin
            pos <= '0;
            phase <= CRC;
          end
        end
        CRC: if (pos == 8'd0) begin
          crc_lo <= data_byte;
          pos <= 8'd1;
        end else begin
          pos <= '0;
          crc_ok <= (kind != KindNone) &&
                    (crc_step(kind_extra(kind), crc) == {data_byte, crc_lo});
          if (signed_f) phase <= SIG;
          else begin
            frame_valid <= (kind != KindNone) && (plen >= kind_min(kind)) &&
              (crc_step(kind_extra(kind), crc) == {data_byte, crc_lo});
            phase <= HUNT;
          end
        end
        SIG: begin
          pos <= pos_next;
          if (pos_next >= SigLen) begin
            frame_valid <= crc_ok && (plen >= kind_min(kind));
            pos <= '0;
            phase <= HUNT;
          end
        end
        default: phase <= HUNT;
      endcase
      if (end_of_datagram) begin
        phase <= HUNT;
        pos <= '0;
      end
    end
  end
endmodule
`default_nettype wire

### design/mfd_queue.sv
// Back end: result queue between parser and consumer.
// Depends on mfd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mfd_queue import mfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire frame_t wdata,
  input  wire logic   rd,
  output frame_t      rdata,
  output logic        empty,
  output logic        almost_full
);
  localparam int unsigned Aw = $clog2(Depth);
  frame_t mem [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0] count;
  logic do_rd;

  assign empty = (count == '0);
  // Keep room for a frame already inside the parser.
  assign almost_full = (count >= (Aw+1)'(Depth - 1));
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (Aw+1)'(wr) - (Aw+1)'(do_rd);
    end
  end

  `CHK_IMPL(no_overflow, clk, rst, wr, count < (Aw+1)'(Depth) || do_rd)
  `CHK_NEXT(count_moves, clk, rst, wr && !do_rd, count == $past(count) + 1'b1)
  `CHK_IMPL(empty_pointers, clk, rst, empty, wp == rp)
endmodule
`default_nettype wire

### design/mavlink_frame_decoder_unit.sv
// Top level of the frame decoder: parser front end and result queue.
// Depends on mfd_pkg, mfd_parser and mfd_queue.
//
// Input channel: drive data_byte/end_of_datagram with push; a byte is taken
// when push is high and full is low. One byte per cycle is sustained while full stays low.
// Result channel: while empty is low the oldest decoded frame sits on the
// result ports; pop takes it. A frame appears once the byte that completes
// it has passed the parser register and then been written into the queue.
// Results wait in a small queue; full rises only when the queue is nearly
// full, so bytes keep flowing while the receiver stalls briefly.
// Reset (rst, synchronous) returns the parser to start-byte hunting and
// empties the queue. Truncated, unknown or bad-CRC frames give no result.
`default_nettype none
module mavlink_frame_decoder_unit import mfd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_datagram,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       msg_kind,
  output logic [7:0]       system_id,
  output logic [7:0]       component_id,
  output logic [31:0]      field_word_0,
  output logic [31:0]      field_word_1,
  output logic [31:0]      field_word_2,
  output logic [31:0]      field_word_3,
  output logic [31:0]      field_word_4,
  output logic [31:0]      field_word_5,
  output logic [31:0]      field_word_6,
  output logic [31:0]      field_word_7
);
  frame_t pf, qf;
  logic pv;

  mfd_parser u_parser (
    .clk, .rst, .in_take(push && !full), .data_byte, .end_of_datagram,
    .frame(pf), .frame_valid(pv)
  );

  mfd_queue #(.Depth(Depth)) u_queue (
    .clk, .rst, .wr(pv), .wdata(pf), .rd(pop), .rdata(qf), .empty,
    .almost_full(full)
  );

  assign msg_kind = qf.kind;
  assign system_id = qf.sys;
  assign component_id = qf.comp;
  assign field_word_0 = qf.words[0];
  assign field_word_1 = qf.words[1];
  assign field_word_2 = qf.words[2];
  assign field_word_3 = qf.words[3];
  assign field_word_4 = qf.words[4];
  assign field_word_5 = qf.words[5];
  assign field_word_6 = qf.words[6];
  assign field_word_7 = qf.words[7];
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for mavlink_frame_decoder_unit: random byte streams of
// well-formed, corrupted and cut-off frames, with decoded frames predicted and compared.
// Depends on the decoder RTL only.
`default_nettype none

// Expected decoded frame and the scoreboard that holds them in order.
typedef struct {
  logic [2:0] kind;
  logic [7:0] sys;
  logic [7:0] comp;
  logic [31:0] words [8];
} decoded_frame_t;

class frame_scoreboard;
  decoded_frame_t pending_frames[$];
  int errors;

  function void note_frame(decoded_frame_t f);
    pending_frames.insert(pending_frames.size(), f);
  endfunction

  function void check_frame(decoded_frame_t got);
    decoded_frame_t want;
    if (pending_frames.size() == 0) begin
      $error("unexpected frame kind=%0d", got.kind);
      errors++;
      return;
    end
    want = pending_frames.pop_front();
    if (got.kind !== want.kind) begin
      $error("msg_kind expected %0h actual %0h", want.kind, got.kind);
      errors++;
    end
    if (got.sys !== want.sys) begin
      $error("system_id expected %0h actual %0h", want.sys, got.sys);
      errors++;
    end
    if (got.comp !== want.comp) begin
      $error("component_id expected %0h actual %0h", want.comp, got.comp);
      errors++;
    end
    for (int i = 0; i < 8; i++)
      if (got.words[i] !== want.words[i]) begin
        $error("field_word_%0d expected %0h actual %0h", i, want.words[i], got.words[i]);
        errors++;
      end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] StartOne = 8'hFE;
  localparam logic [7:0] StartTwo = 8'hFD;
  localparam int SignatureBytes = 13;
  localparam longint CycleLimit = 2000000;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    HUNT, HEADER, PAYLOAD, CHECKSUM, SIGNATURE
  } parse_phase_t;

  logic clk, rst, push, full, empty, pop, end_of_datagram;
  logic [7:0] data_byte;
  logic [2:0] msg_kind;
  logic [7:0] system_id, component_id;
  logic [31:0] field_word_0, field_word_1, field_word_2, field_word_3;
  logic [31:0] field_word_4, field_word_5, field_word_6, field_word_7;

  mavlink_frame_decoder_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .data_byte(data_byte), .end_of_datagram(end_of_datagram),
    .empty(empty), .pop(pop), .msg_kind(msg_kind),
    .system_id(system_id), .component_id(component_id),
    .field_word_0(field_word_0), .field_word_1(field_word_1),
    .field_word_2(field_word_2), .field_word_3(field_word_3),
    .field_word_4(field_word_4), .field_word_5(field_word_5),
    .field_word_6(field_word_6), .field_word_7(field_word_7)
  );

  frame_scoreboard board = new();
  longint cycle_count;
  int bytes_sent;

  // Known messages: ids, CRC extra bytes, minimum payload lengths.
  logic [23:0] known_ids [7] = '{24'd0, 24'd24, 24'd30, 24'd33, 24'd42, 24'd136, 24'd242};
  logic [7:0] crc_extras [7] = '{8'd50, 8'd24, 8'd39, 8'd104, 8'd28, 8'd1, 8'd104};
  logic [7:0] min_lengths [7] = '{8'd9, 8'd30, 8'd28, 8'd28, 8'd2, 8'd22, 8'd52};

  // Predictor state.
  parse_phase_t phase;
  bit version_two, signed_frame, crc_ok;
  logic [7:0] position, payload_len, sender_sys, sender_comp;
  logic [23:0] msg_id;
  logic [15:0] crc_acc, crc_rx;
  logic [31:0] words [8];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [15:0] mcrf4xx_update(logic [7:0] b, logic [15:0] c);
    logic [7:0] t;
    t = b ^ c[7:0];
    t = t ^ (t << 4);
    return (c >> 8) ^ ({8'd0, t} << 8) ^ ({8'd0, t} << 3) ^ ({8'd0, t} >> 4);
  endfunction

  function automatic int kind_index(logic [23:0] id);
    for (int k = 0; k < 7; k++) if (known_ids[k] == id) return k;
    return 7;
  endfunction

  function automatic logic [31:0] sign_extend16(logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function void clear_decoder();
    phase = HUNT;
    version_two = 0; signed_frame = 0; crc_ok = 0;
    position = 0; payload_len = 0; sender_sys = 0; sender_comp = 0;
    msg_id = 0; crc_acc = 16'hFFFF; crc_rx = 0;
    for (int i = 0; i < 8; i++) words[i] = 0;
  endfunction

  // Word and lane for a payload offset of a known message; word -1 when not captured.
  function automatic void field_slot(int k, int p, output int w, output int lane);
    w = -1;
    lane = 0;
    case (k)
      0: if (p >= 4 && p <= 7) w = p - 4;
      1: if (p >= 8 && p <= 19) begin w = (p - 8) / 4; lane = (p - 8) % 4; end
         else if (p == 28) w = 3;
         else if (p == 29) w = 4;
      2: if (p >= 4 && p <= 15) begin w = (p - 4) / 4; lane = (p - 4) % 4; end
      3: if (p >= 4 && p <= 19) begin w = (p - 4) / 4; lane = (p - 4) % 4; end
         else if (p >= 20 && p <= 27) begin w = 4 + (p - 20) / 2; lane = (p - 20) % 2; end
      4: if (p <= 1) begin w = 0; lane = p; end
      5: if (p <= 7) begin w = p / 4; lane = p % 4; end
         else if (p >= 10 && p <= 17) begin w = 2 + (p - 10) / 4; lane = (p - 10) % 4; end
         else if (p >= 18 && p <= 21) begin w = 4 + (p - 18) / 2; lane = (p - 18) % 2; end
      6: if (p <= 11) begin w = p / 4; lane = p % 4; end
      default: ;
    endcase
  endfunction

  function void finish_frame();
    int k;
    decoded_frame_t f;
    k = kind_index(msg_id);
    if (k == 7 || !crc_ok || payload_len < min_lengths[k]) return;
    f.kind = k[2:0];
    f.sys = sender_sys;
    f.comp = sender_comp;
    for (int i = 0; i < 8; i++) f.words[i] = words[i];
    case (k)
      0: f.words[4] = words[2][7] ? 32'd1 : 32'd0;
      1: if (words[4] == 32'd255) f.words[4] = 32'hFFFFFFFF;
      3: begin
        f.words[4] = sign_extend16(words[4]);
        f.words[5] = sign_extend16(words[5]);
        f.words[6] = sign_extend16(words[6]);
        if (words[7] == 32'd65535) f.words[7] = 0;
      end
      default: ;
    endcase
    board.note_frame(f);
  endfunction

  // Advance the predictor by one accepted byte.
  function void decode_byte(logic [7:0] b, logic eod);
    int k, w, lane;
    case (phase)
      HUNT:
        if (b == StartOne || b == StartTwo) begin
          clear_decoder();
          version_two = (b == StartTwo);
          phase = HEADER;
        end
      HEADER: begin
        crc_acc = mcrf4xx_update(b, crc_acc);
        if (position == 0) payload_len = b;
        if (version_two) begin
          if (position == 1) signed_frame = b[0];
          else if (position == 4) sender_sys = b;
          else if (position == 5) sender_comp = b;
          else if (position >= 6 && position <= 8)
            msg_id |= {16'd0, b} << (8 * (position - 6));
        end else begin
          if (position == 2) sender_sys = b;
          else if (position == 3) sender_comp = b;
          else if (position == 4) msg_id = {16'd0, b};
        end
        position++;
        if (position >= (version_two ? 9 : 5)) begin
          position = 0;
          phase = (payload_len != 0) ? PAYLOAD : CHECKSUM;
        end
      end
      PAYLOAD: begin
        crc_acc = mcrf4xx_update(b, crc_acc);
        field_slot(kind_index(msg_id), position, w, lane);
        if (w >= 0) words[w] |= {24'd0, b} << (8 * lane);
        position++;
        if (position >= payload_len) begin
          position = 0;
          phase = CHECKSUM;
        end
      end
      CHECKSUM:
        if (position == 0) begin
          crc_rx = {8'd0, b};
          position = 1;
        end else begin
          crc_rx[15:8] = b;
          k = kind_index(msg_id);
          crc_ok = (k != 7) && (mcrf4xx_update(crc_extras[k], crc_acc) == crc_rx);
          position = 0;
          if (signed_frame) phase = SIGNATURE;
          else begin
            finish_frame();
            phase = HUNT;
          end
        end
      SIGNATURE: begin
        position++;
        if (position >= SignatureBytes) begin
          finish_frame();
          position = 0;
          phase = HUNT;
        end
      end
      default: phase = HUNT;
    endcase
    if (eod) clear_decoder();
  endfunction

  // Send one byte; random idle before it, wait for acceptance.
  // push stays high after acceptance until the next byte or an idle gap.
  task automatic send_byte(logic [7:0] b, logic eod);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1;
    data_byte <= b;
    end_of_datagram <= eod;
    do @(posedge clk); while (full);
    decode_byte(b, eod);
    bytes_sent++;
  endtask

  // Stop sending and wait until every expected frame has been popped.
  task automatic drain_results();
    push <= 0;
    @(posedge clk);
    while (board.pending_frames.size() != 0) @(posedge clk);
  endtask

  // Build a frame byte list and send it. corrupt: 0 clean, 1 bad CRC, 2 truncate.
  task automatic send_frame(bit v2, logic [23:0] id, int len, bit sig, int corrupt,
                            bit extreme);
    logic [7:0] bytes[$];
    logic [15:0] c;
    int k, cut;
    bytes.insert(bytes.size(), v2 ? StartTwo : StartOne);
    bytes.insert(bytes.size(), len[7:0]);
    if (v2) begin
      bytes.insert(bytes.size(), {7'($urandom_range(0, 127)), sig});
      bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    end
    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    bytes.insert(bytes.size(), extreme ? 8'hFF : 8'($urandom_range(0, 255)));
    bytes.insert(bytes.size(), extreme ? 8'h00 : 8'($urandom_range(0, 255)));
    bytes.insert(bytes.size(), id[7:0]);
    if (v2) begin
      bytes.insert(bytes.size(), id[15:8]);
      bytes.insert(bytes.size(), id[23:16]);
    end
    for (int i = 0; i < len; i++)
      bytes.insert(bytes.size(), extreme ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                         : 8'($urandom_range(0, 255)));
    c = 16'hFFFF;
    for (int i = 1; i < bytes.size(); i++) c = mcrf4xx_update(bytes[i], c);
    k = kind_index(id);
    c = mcrf4xx_update(k == 7 ? 8'd0 : crc_extras[k], c);
    if (corrupt == 1) c ^= 16'd1 << $urandom_range(0, 15);
    bytes.insert(bytes.size(), c[7:0]);
    bytes.insert(bytes.size(), c[15:8]);
    if (v2 && sig)
      for (int i = 0; i < SignatureBytes; i++)
        bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
    cut = (corrupt == 2) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int i = 0; i < cut; i++)
      send_byte(bytes[i], (corrupt == 2 && i == cut - 1) || (i == cut - 1 && $urandom_range(0, 3) == 0));
  endtask

  task automatic send_random_frame();
    int k, len, r;
    logic [23:0] id;
    bit v2;
    v2 = $urandom_range(0, 1);
    k = $urandom_range(0, 7);
    id = (k == 7) ? (v2 ? {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd200}
                        : 24'd200)
                  : known_ids[k];
    r = $urandom_range(0, 9);
    if (k == 7) len = $urandom_range(0, 20);
    else if (r == 0) len = $urandom_range(0, min_lengths[k]);
    else len = min_lengths[k] + $urandom_range(0, 6);
    if ($urandom_range(0, 60) == 0) len = 255;
    send_frame(v2, id, len, v2 && $urandom_range(0, 3) == 0,
               r == 1 ? 1 : (r == 2 ? 2 : 0), $urandom_range(0, 9) == 0);
    // line noise between frames
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Result side: random stalls, check each popped frame.
  initial begin
    decoded_frame_t got;
    int gap;
    pop <= 0;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1;
      do @(posedge clk); while (empty);
      got.kind = msg_kind; got.sys = system_id; got.comp = component_id;
      got.words[0] = field_word_0; got.words[1] = field_word_1;
      got.words[2] = field_word_2; got.words[3] = field_word_3;
      got.words[4] = field_word_4; got.words[5] = field_word_5;
      got.words[6] = field_word_6; got.words[7] = field_word_7;
      board.check_frame(got);
    end
  end

  initial begin
    int frames;
    cycle_count = 0;
    bytes_sent = 0;
    rst <= 1; push <= 0; data_byte <= 0; end_of_datagram <= 0;
    clear_decoder();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: each kind at minimum length, v1 and v2, signed, bad CRC, unknown.
    for (int k = 0; k < 7; k++) send_frame(k % 2, known_ids[k], min_lengths[k], 0, 0, 1);
    send_frame(1, 24'd33, 28, 1, 0, 0);
    send_frame(0, 24'd0, 9, 0, 1, 0);
    send_frame(1, 24'd999, 4, 0, 0, 0);
    send_frame(1, 24'd42, 1, 0, 0, 0);
    send_frame(0, 24'd42, 0, 0, 0, 0);
    send_frame(1, 24'd136, 22, 0, 2, 0);

    // Hold off until every frame is out.
    drain_results();
    repeat (4) @(posedge clk);

    frames = 0;
    while (bytes_sent < 1900) begin
      send_random_frame();
      frames++;
      if (frames % 16 == 0) drain_results();
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

### mavlink_frame_decoder_unit.f
+incdir+design
design/mfd_pkg.sv
design/mfd_parser.sv
design/mfd_queue.sv
design/mavlink_frame_decoder_unit.sv
tb/tb_top.sv
